// ===== hw/rtl/ejwn_pkg.sv =====
// ejwn_pkg: shared types, byte codes and lookup functions for the EUC-JP
// width normalizer. No dependencies.
`default_nettype none

package ejwn_pkg;

    // lead and mark byte codes
    localparam logic [7:0] LEAD_SS2     = 8'h8e;  // half-width kana
    localparam logic [7:0] LEAD_SS3     = 8'h8f;  // three-byte plane
    localparam logic [7:0] LEAD_SYMBOL  = 8'ha1;
    localparam logic [7:0] LEAD_ALNUM   = 8'ha3;
    localparam logic [7:0] LEAD_HIRA    = 8'ha4;
    localparam logic [7:0] LEAD_KATA    = 8'ha5;
    localparam logic [7:0] HW_DAKUTEN   = 8'hde;
    localparam logic [7:0] HW_HANDAKU   = 8'hdf;
    localparam logic [7:0] FW_DAKUTEN   = 8'hab;
    localparam logic [7:0] FW_HANDAKU   = 8'hac;
    localparam logic [7:0] KANA_U       = 8'ha6;
    localparam logic [7:0] KATA_VU      = 8'hf4;
    localparam logic [7:0] KANA_FIRST   = 8'ha6;
    localparam logic [7:0] KANA_LAST    = 8'hdf;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [1:0] length;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] ascii;
    } sym_map_t;

    // full-width symbol (second byte after A1) to ASCII
    function automatic sym_map_t sym_lookup(input logic [7:0] b);
        sym_map_t r;
        r.hit = 1'b1;
        unique case (b)
            8'ha1: r.ascii = 8'h20;
            8'ha4: r.ascii = 8'h2c;
            8'ha5: r.ascii = 8'h2e;
            8'ha7: r.ascii = 8'h3a;
            8'ha8: r.ascii = 8'h3b;
            8'ha9: r.ascii = 8'h3f;
            8'haa: r.ascii = 8'h21;
            8'hb0: r.ascii = 8'h5e;
            8'hb1: r.ascii = 8'h7e;
            8'hb2: r.ascii = 8'h5f;
            8'hbf: r.ascii = 8'h2f;
            8'hc3: r.ascii = 8'h7c;
            8'hc6: r.ascii = 8'h60;
            8'hc7: r.ascii = 8'h27;
            8'hc9: r.ascii = 8'h22;
            8'hca: r.ascii = 8'h28;
            8'hcb: r.ascii = 8'h29;
            8'hce: r.ascii = 8'h5b;
            8'hcf: r.ascii = 8'h5d;
            8'hd0: r.ascii = 8'h7b;
            8'hd1: r.ascii = 8'h7d;
            8'hdc: r.ascii = 8'h2b;
            8'hdd: r.ascii = 8'h2d;
            8'he1: r.ascii = 8'h3d;
            8'he3: r.ascii = 8'h3c;
            8'he4: r.ascii = 8'h3e;
            8'hef: r.ascii = 8'h5c;
            8'hf0: r.ascii = 8'h24;
            8'hf3: r.ascii = 8'h25;
            8'hf4: r.ascii = 8'h23;
            8'hf5: r.ascii = 8'h26;
            8'hf6: r.ascii = 8'h2a;
            8'hf7: r.ascii = 8'h40;
            default:
            begin
                r.hit   = 1'b0;
                r.ascii = b;
            end
        endcase
        return r;
    endfunction

    // half-width kana A6..DF to second byte of the full-width form
    function automatic logic [7:0] kana_second(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'ha6: r = 8'hf2;  8'ha7: r = 8'ha1;  8'ha8: r = 8'ha3;
            8'ha9: r = 8'ha5;  8'haa: r = 8'ha7;  8'hab: r = 8'ha9;
            8'hac: r = 8'he3;  8'had: r = 8'he5;  8'hae: r = 8'he7;
            8'haf: r = 8'hc3;  8'hb0: r = 8'hbc;  8'hb1: r = 8'ha2;
            8'hb2: r = 8'ha4;  8'hb3: r = 8'ha6;  8'hb4: r = 8'ha8;
            8'hb5: r = 8'haa;  8'hb6: r = 8'hab;  8'hb7: r = 8'had;
            8'hb8: r = 8'haf;  8'hb9: r = 8'hb1;  8'hba: r = 8'hb3;
            8'hbb: r = 8'hb5;  8'hbc: r = 8'hb7;  8'hbd: r = 8'hb9;
            8'hbe: r = 8'hbb;  8'hbf: r = 8'hbd;  8'hc0: r = 8'hbf;
            8'hc1: r = 8'hc1;  8'hc2: r = 8'hc4;  8'hc3: r = 8'hc6;
            8'hc4: r = 8'hc8;  8'hc5: r = 8'hca;  8'hc6: r = 8'hcb;
            8'hc7: r = 8'hcc;  8'hc8: r = 8'hcd;  8'hc9: r = 8'hce;
            8'hca: r = 8'hcf;  8'hcb: r = 8'hd2;  8'hcc: r = 8'hd5;
            8'hcd: r = 8'hd8;  8'hce: r = 8'hdb;  8'hcf: r = 8'hde;
            8'hd0: r = 8'hdf;  8'hd1: r = 8'he0;  8'hd2: r = 8'he1;
            8'hd3: r = 8'he2;  8'hd4: r = 8'he4;  8'hd5: r = 8'he6;
            8'hd6: r = 8'he8;  8'hd7: r = 8'he9;  8'hd8: r = 8'hea;
            8'hd9: r = 8'heb;  8'hda: r = 8'hec;  8'hdb: r = 8'hed;
            8'hdc: r = 8'hef;  8'hdd: r = 8'hf3;  8'hde: r = 8'hab;
            8'hdf: r = 8'hac;
            default: r = b;
        endcase
        return r;
    endfunction

    // kana whose voiced form is the next code
    function automatic logic voices_plus_one(input logic [7:0] c);
        logic r;
        unique case (c)
            8'hab, 8'had, 8'haf, 8'hb1, 8'hb3,
            8'hb5, 8'hb7, 8'hb9, 8'hbb, 8'hbd,
            8'hbf, 8'hc1, 8'hc4, 8'hc6, 8'hc8,
            8'hcf, 8'hd2, 8'hd5, 8'hd8, 8'hdb: r = 1'b1;
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

    // ha row: takes the semi-voiced mark (plus 2)
    function automatic logic is_ha_row(input logic [7:0] c);
        return (c == 8'hcf) || (c == 8'hd2) || (c == 8'hd5) ||
               (c == 8'hd8) || (c == 8'hdb);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eucjp_width_normalizer_unit.sv =====
// eucjp_width_normalizer_unit: EUC-JP full/half-width normalizer with
// held-character combining and a four-entry result queue. Uses ejwn_pkg.
`default_nettype none
//
// Usage
//   Input channel (in_valid/in_ready): one EUC-JP character per item in
//   lead_byte/second_byte/third_byte, or a flush (flush = 1) at end of text.
//   Output channel (out_valid/out_ready): one character per item, with
//   out_length valid bytes; last_of_run marks the final result of an input.
//   Each input yields zero, one or two results. Two-byte results are held
//   back one character so a following voiced/semi-voiced mark can fold in.
//   A one- or three-byte result is written into the queue when its input is
//   accepted. A two-byte result comes out when a later input that is not a
//   combining mark (or a flush) releases it.
//   Throughput: the classify/convert logic takes one input per cycle while
//   in_ready is high, and the output drains one result per cycle while
//   out_ready is high, so the output port sets the sustained rate, which is
//   lower for two-result inputs (held release plus one-/three-byte character).
//   Results go into a 4-entry queue; in_ready is high while at most two
//   entries are occupied, so an input is taken even while out_ready is low.
//   A stalled receiver lets the queue fill past two entries, then in_ready drops.
//   Reset empties the queue and drops any held character.

module eucjp_width_normalizer_unit
    import ejwn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] lead_byte,
    input  wire logic [7:0] second_byte,
    input  wire logic [7:0] third_byte,
    input  wire logic       flush,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_first,
    output logic [7:0]      out_second,
    output logic [7:0]      out_third,
    output logic [1:0]      out_length,
    output logic            last_of_run
);

    // held two-byte character
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_first_reg, hold_first_next;
    logic [7:0] hold_second_reg, hold_second_next;

    // result queue
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic     accept, pop;
    logic     is_daku, is_handaku, combine;
    sym_map_t sym;
    result_t  new_res, held_res, item0, item1;
    logic     emit_hold, emit_new;
    logic [1:0] push_cnt;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    // ---- classify and convert the incoming character ----
    always_comb
    begin
        sym     = sym_lookup(second_byte);
        new_res = '{first: lead_byte, second: 8'h00, third: 8'h00,
                    length: LEN_TWO, last: 1'b1};
        if (!lead_byte[7])
        begin
            new_res.length = LEN_ONE;
        end
        else if (lead_byte == LEAD_SS3)
        begin
            new_res.second = second_byte;
            new_res.third  = third_byte;
            new_res.length = LEN_THREE;
        end
        else
        begin
            new_res.second = second_byte;
            if (lead_byte == LEAD_ALNUM &&
                ((second_byte >= 8'hb0 && second_byte <= 8'hb9) ||
                 (second_byte >= 8'hc1 && second_byte <= 8'hda) ||
                 (second_byte >= 8'he1 && second_byte <= 8'hfa)))
            begin
                new_res.first  = {1'b0, second_byte[6:0]};
                new_res.second = 8'h00;
                new_res.length = LEN_ONE;
            end
            else if (lead_byte == LEAD_SYMBOL)
            begin
                if (sym.hit)
                begin
                    new_res.first  = sym.ascii;
                    new_res.second = 8'h00;
                    new_res.length = LEN_ONE;
                end
            end
            else if (lead_byte == LEAD_SS2 &&
                     second_byte >= KANA_FIRST && second_byte <= KANA_LAST)
            begin
                new_res.second = kana_second(second_byte);
                new_res.first  = (second_byte == 8'hb0 ||
                                  second_byte == HW_DAKUTEN ||
                                  second_byte == HW_HANDAKU) ? LEAD_SYMBOL : LEAD_KATA;
            end
        end
    end

    // ---- combining mark against the held character ----
    assign is_daku    = (lead_byte == LEAD_SS2 && second_byte == HW_DAKUTEN) ||
                        (lead_byte == LEAD_SYMBOL && second_byte == FW_DAKUTEN);
    assign is_handaku = (lead_byte == LEAD_SS2 && second_byte == HW_HANDAKU) ||
                        (lead_byte == LEAD_SYMBOL && second_byte == FW_HANDAKU);

    assign combine = !flush && hold_valid_reg &&
                     (hold_first_reg == LEAD_HIRA || hold_first_reg == LEAD_KATA) &&
                     ((is_daku && (hold_second_reg == KANA_U ||
                                   voices_plus_one(hold_second_reg))) ||
                      (is_handaku && is_ha_row(hold_second_reg)));

    // ---- results of this input ----
    always_comb
    begin
        held_res  = '{first: hold_first_reg, second: hold_second_reg, third: 8'h00,
                      length: LEN_TWO, last: 1'b1};
        emit_hold = hold_valid_reg && (flush || !combine);
        emit_new  = !flush && !combine && (new_res.length != LEN_TWO);
        item1     = new_res;
        if (emit_hold)
        begin
            item0      = held_res;
            item0.last = !emit_new;
        end
        else
        begin
            item0 = new_res;
        end
        push_cnt = accept ? ({1'b0, emit_hold} + {1'b0, emit_new}) : 2'd0;
    end

    // ---- held character next state ----
    always_comb
    begin
        hold_valid_next  = hold_valid_reg;
        hold_first_next  = hold_first_reg;
        hold_second_next = hold_second_reg;
        if (accept)
        begin
            if (flush)
            begin
                hold_valid_next  = 1'b0;
                hold_first_next  = 8'h00;
                hold_second_next = 8'h00;
            end
            else if (combine)
            begin
                if (is_daku && hold_second_reg == KANA_U)
                begin
                    hold_first_next  = LEAD_KATA;
                    hold_second_next = KATA_VU;
                end
                else if (is_daku)
                begin
                    hold_second_next = hold_second_reg + 8'd1;
                end
                else
                begin
                    hold_second_next = hold_second_reg + 8'd2;
                end
            end
            else if (new_res.length == LEN_TWO)
            begin
                hold_valid_next  = 1'b1;
                hold_first_next  = new_res.first;
                hold_second_next = new_res.second;
            end
            else
            begin
                hold_valid_next = 1'b0;
            end
        end
    end

    // ---- queue pointers ----
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            hold_first_reg  <= 8'h00;
            hold_second_reg <= 8'h00;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            hold_valid_reg  <= hold_valid_next;
            hold_first_reg  <= hold_first_next;
            hold_second_reg <= hold_second_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= item0;
        end
        if (push_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= item1;
        end
    end

    // room for two results means any input can be taken
    assign in_ready    = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid   = (count_reg != '0);
    assign out_first   = queue_reg[rd_ptr_reg].first;
    assign out_second  = queue_reg[rd_ptr_reg].second;
    assign out_third   = queue_reg[rd_ptr_reg].third;
    assign out_length  = queue_reg[rd_ptr_reg].length;
    assign last_of_run = queue_reg[rd_ptr_reg].last;

    // ---- assertions ----
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && flush) |=> !hold_valid_reg)
        else $error("held character survived a flush");

    a_combine_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && combine) |=>
            (hold_valid_reg && $stable(count_reg) == 1'b0 ? 1'b1 : hold_valid_reg))
        else $error("combining mark lost the held character");

endmodule

`default_nettype wire
